[hdl/rdz_pkg.sv]
package rdz_pkg;

    // Sample kinds carried on the mode field.
    localparam logic [1:0] MODE_BOOL  = 2'd0;
    localparam logic [1:0] MODE_AXIS1 = 2'd1;
    localparam logic [1:0] MODE_AXIS2 = 2'd2;
    localparam logic [1:0] MODE_AXIS3 = 2'd3;

    // Width of the dead zone register, unsigned Q0.15.
    localparam int DZ_BITS = 15;

endpackage

[hdl/radial_dead_zone_rescale.sv]
// Scaled radial dead zone for controller samples. Each input transaction carries a kind
// (boolean, one, two or three axes) and signed Q1.(SAMPLE_BITS-1) components. A boolean
// passes through. A single axis whose absolute value is below the dead zone becomes zero,
// otherwise it passes unchanged. A two- or three-axis vector whose squared magnitude is
// below the squared dead zone becomes zero; otherwise each component c is replaced by
// c * (mag - dz) / ((1 - dz) * mag), rounded to nearest with ties away from zero and
// saturated. The dead zone register is written over its own valid/ready channel, which is
// always ready, and must only be changed while the pipeline is empty. The block takes one
// transaction per clock while the output is not stalled and returns one result per
// transaction in order. The pipeline holds stage registers for the absolute values, the
// squares and the dead zone test; a square root that retires one root bit per stage over
// SAMPLE_BITS stages; the rescale products and then the dividend; three lane dividers that
// retire one quotient bit per stage over SAMPLE_BITS stages; and a final output register
// that saturates the result. The whole pipeline advances together whenever the output
// register is empty or being taken, so an output stall holds every stage in place.
module radial_dead_zone_rescale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rdz_pkg::DZ_BITS-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic                          bool_in,
    input  logic signed [SAMPLE_BITS-1:0] in_x,
    input  logic signed [SAMPLE_BITS-1:0] in_y,
    input  logic signed [SAMPLE_BITS-1:0] in_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_mode,
    output logic                          bool_out,
    output logic signed [SAMPLE_BITS-1:0] out_x,
    output logic signed [SAMPLE_BITS-1:0] out_y,
    output logic signed [SAMPLE_BITS-1:0] out_z,
    output logic                          in_dead_zone
);

    localparam int N  = SAMPLE_BITS;
    localparam int F  = N - 1;      // fraction bits
    localparam int AW = N;          // absolute value of a component
    localparam int SW = 2 * N;      // squares and their sum
    localparam int RW = N;          // root and quotient
    localparam int PW = 2 * N;      // rescale products
    localparam int NW = 3 * N - 1;  // dividend
    localparam logic [RW-1:0] ONE_Q = RW'(1) << F;

    typedef struct packed {
        logic                vld;
        logic [1:0]          mode;
        logic                bval;
        logic [2:0]          neg;
        logic [2:0][AW-1:0]  a;
        logic [N-1:0]        x;
        logic                dz_hit;
        logic                zero;
    } item_t;

    typedef struct packed {
        item_t               it;
        logic [2:0][SW-1:0]  sq;
        logic [SW-1:0]       dd;
    } sq_t;

    typedef struct packed {
        item_t               it;
        logic [SW-1:0]       s;
    } sum_t;

    typedef struct packed {
        item_t               it;
        logic [SW-1:0]       rem;
        logic [RW-1:0]       root;
    } root_t;

    typedef struct packed {
        item_t               it;
        logic [2:0][PW-1:0]  num;
        logic [PW-1:0]       den;
    } prod_t;

    typedef struct packed {
        item_t               it;
        logic [PW-1:0]       den;
        logic [2:0][NW-1:0]  rem;
        logic [2:0][RW-1:0]  q;
        logic [2:0]          ovf;
    } div_t;

    function automatic logic [AW-1:0] abs_of(logic [N-1:0] v);
        logic [N:0] e;
        e = {v[N-1], v};
        if (v[N-1])
        begin
            e = ~e + 1'b1;
        end
        return e[AW-1:0];
    endfunction

    function automatic logic [N-1:0] sat_lane(logic [RW-1:0] q, logic ovf, logic neg);
        logic [N-1:0] r;
        if (neg)
        begin
            r = (ovf || q > ONE_Q) ? ONE_Q : (~q + 1'b1);
        end
        else
        begin
            r = (ovf || q > ONE_Q - 1'b1) ? (ONE_Q - 1'b1) : q;
        end
        return r;
    endfunction

    logic [rdz_pkg::DZ_BITS-1:0] dead_zone_reg;
    logic [F-1:0]                dz;
    logic                        adv;

    sq_t   s0_reg, s0_next;
    item_t s0i_reg, s0i_next;
    sum_t  s2_reg, s2_next;
    root_t sr_reg [RW];
    root_t sr_next [RW];
    prod_t pm_reg, pm_next;
    div_t  dp_reg, dp_next;
    div_t  dv_reg [RW];
    div_t  dv_next [RW];

    logic                out_valid_reg;
    logic [1:0]          out_mode_reg;
    logic                bool_out_reg;
    logic [N-1:0]        out_x_reg, out_x_next;
    logic [N-1:0]        out_y_reg, out_y_next;
    logic [N-1:0]        out_z_reg, out_z_next;
    logic                in_dead_zone_reg;

    // Configuration: the register is always ready to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= '0;
        end
        else if (cfg_valid)
        begin
            dead_zone_reg <= cfg_data;
        end
    end

    // The dead zone in the sample's fraction format.
    generate
        if (F >= rdz_pkg::DZ_BITS)
        begin : g_dz_up
            logic [F+rdz_pkg::DZ_BITS-1:0] dz_wide;
            assign dz_wide = (F + rdz_pkg::DZ_BITS)'(dead_zone_reg) << (F - rdz_pkg::DZ_BITS);
            assign dz      = dz_wide[F-1:0];
        end
        else
        begin : g_dz_down
            assign dz = F'(dead_zone_reg >> (rdz_pkg::DZ_BITS - F));
        end
    endgenerate

    // Every stage moves together whenever the output register can take a new result.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Stage 0: capture the sample, mask unused axes and take absolute values.
    always_comb
    begin
        logic use_y;
        logic use_z;
        use_y = mode[1];
        use_z = (mode == rdz_pkg::MODE_AXIS3);
        s0i_next        = '0;
        s0i_next.vld    = in_valid;
        s0i_next.mode   = mode;
        s0i_next.bval   = (mode == rdz_pkg::MODE_BOOL) && bool_in;
        s0i_next.neg[0] = in_x[N-1];
        s0i_next.neg[1] = use_y && in_y[N-1];
        s0i_next.neg[2] = use_z && in_z[N-1];
        s0i_next.a[0]   = abs_of(in_x);
        s0i_next.a[1]   = use_y ? abs_of(in_y) : '0;
        s0i_next.a[2]   = use_z ? abs_of(in_z) : '0;
        s0i_next.x      = in_x;
    end

    // Stage 1: squares of the components and of the dead zone.
    always_comb
    begin
        s0_next.it    = s0i_reg;
        s0_next.sq[0] = SW'(s0i_reg.a[0]) * SW'(s0i_reg.a[0]);
        s0_next.sq[1] = SW'(s0i_reg.a[1]) * SW'(s0i_reg.a[1]);
        s0_next.sq[2] = SW'(s0i_reg.a[2]) * SW'(s0i_reg.a[2]);
        s0_next.dd    = SW'(dz) * SW'(dz);
    end

    // Stage 2: squared magnitude and the dead zone test.
    always_comb
    begin
        s2_next.it   = s0_reg.it;
        s2_next.s    = s0_reg.sq[0] + s0_reg.sq[1] + s0_reg.sq[2];
        s2_next.it.zero = (s2_next.s == '0);
        case (s0_reg.it.mode) inside
            rdz_pkg::MODE_AXIS1:
                s2_next.it.dz_hit = (s0_reg.it.a[0] < AW'(dz));
            rdz_pkg::MODE_AXIS2, rdz_pkg::MODE_AXIS3:
                s2_next.it.dz_hit = (s2_next.s < s0_reg.dd);
            default:
                s2_next.it.dz_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0i_reg <= '0;
            s0_reg  <= '0;
            s2_reg  <= '0;
        end
        else if (adv)
        begin
            s0i_reg <= s0i_next;
            s0_reg  <= s0_next;
            s2_reg  <= s2_next;
        end
    end

    // Square root: each stage decides one root bit, most significant first.
    generate
        for (genvar k = 0; k < RW; k++)
        begin : g_sqrt
            localparam int I = F - k;
            root_t        src;
            logic [SW-1:0] trial;

            if (k == 0)
            begin : g_first
                assign src.it   = s2_reg.it;
                assign src.rem  = s2_reg.s;
                assign src.root = '0;
            end
            else
            begin : g_next
                assign src = sr_reg[k-1];
            end

            assign trial = (SW'(src.root) << (I + 1)) | (SW'(1) << (2 * I));

            always_comb
            begin
                sr_next[k] = src;
                if (src.rem >= trial)
                begin
                    sr_next[k].rem  = src.rem - trial;
                    sr_next[k].root = src.root | (RW'(1) << I);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sr_reg[k] <= '0;
                end
                else if (adv)
                begin
                    sr_reg[k] <= sr_next[k];
                end
            end
        end
    endgenerate

    // Rescale products: numerator |c|*(mag-dz) per lane, denominator (1-dz)*mag.
    always_comb
    begin
        logic [RW-1:0] mag;
        logic [RW-1:0] mdz;
        mag = sr_reg[RW-1].root;
        mdz = mag - RW'(dz);
        pm_next.it     = sr_reg[RW-1].it;
        pm_next.num[0] = PW'(sr_reg[RW-1].it.a[0]) * PW'(mdz);
        pm_next.num[1] = PW'(sr_reg[RW-1].it.a[1]) * PW'(mdz);
        pm_next.num[2] = PW'(sr_reg[RW-1].it.a[2]) * PW'(mdz);
        pm_next.den    = PW'(ONE_Q - RW'(dz)) * PW'(mag);
    end

    // Dividend with the rounding half folded in, and the early overflow test.
    always_comb
    begin
        logic [NW:0] dtop;
        dtop       = (NW + 1)'(pm_reg.den) << (F + 1);
        dp_next.it  = pm_reg.it;
        dp_next.den = pm_reg.den;
        dp_next.q   = '0;
        for (int c = 0; c < 3; c++)
        begin
            dp_next.rem[c] = (NW'(pm_reg.num[c]) << F) + NW'(pm_reg.den >> 1);
            dp_next.ovf[c] = ({1'b0, dp_next.rem[c]} >= dtop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg <= '0;
            dp_reg <= '0;
        end
        else if (adv)
        begin
            pm_reg <= pm_next;
            dp_reg <= dp_next;
        end
    end

    // Restoring division: each stage decides one quotient bit in all three lanes.
    generate
        for (genvar k = 0; k < RW; k++)
        begin : g_div
            localparam int J = F - k;
            div_t        src;
            logic [NW:0] dsh;

            if (k == 0)
            begin : g_first
                assign src = dp_reg;
            end
            else
            begin : g_next
                assign src = dv_reg[k-1];
            end

            assign dsh = (NW + 1)'(src.den) << J;

            always_comb
            begin
                dv_next[k] = src;
                for (int c = 0; c < 3; c++)
                begin
                    if ({1'b0, src.rem[c]} >= dsh)
                    begin
                        dv_next[k].rem[c]  = src.rem[c] - dsh[NW-1:0];
                        dv_next[k].q[c][J] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[k] <= '0;
                end
                else if (adv)
                begin
                    dv_reg[k] <= dv_next[k];
                end
            end
        end
    endgenerate

    // Output stage: saturate and select by sample kind.
    always_comb
    begin
        div_t d;
        d = dv_reg[RW-1];
        out_x_next = '0;
        out_y_next = '0;
        out_z_next = '0;
        case (d.it.mode) inside
            rdz_pkg::MODE_AXIS1:
            begin
                if (!d.it.dz_hit)
                begin
                    out_x_next = d.it.x;
                end
            end
            rdz_pkg::MODE_AXIS2, rdz_pkg::MODE_AXIS3:
            begin
                if (!d.it.dz_hit && !d.it.zero)
                begin
                    out_x_next = sat_lane(d.q[0], d.ovf[0], d.it.neg[0]);
                    out_y_next = sat_lane(d.q[1], d.ovf[1], d.it.neg[1]);
                    out_z_next = sat_lane(d.q[2], d.ovf[2], d.it.neg[2]);
                end
            end
            default:
            begin
                out_x_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            out_mode_reg     <= '0;
            bool_out_reg     <= 1'b0;
            out_x_reg        <= '0;
            out_y_reg        <= '0;
            out_z_reg        <= '0;
            in_dead_zone_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg    <= dv_reg[RW-1].it.vld;
            out_mode_reg     <= dv_reg[RW-1].it.mode;
            bool_out_reg     <= dv_reg[RW-1].it.bval;
            out_x_reg        <= out_x_next;
            out_y_reg        <= out_y_next;
            out_z_reg        <= out_z_next;
            in_dead_zone_reg <= dv_reg[RW-1].it.dz_hit;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_mode     = out_mode_reg;
    assign bool_out     = bool_out_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign in_dead_zone = in_dead_zone_reg;

    // A sample inside the dead zone always comes out as the zero vector.
    a_dead_zone_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_dead_zone |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("dead zone result is not zero");

    // Booleans never report the dead zone, and only booleans carry a button value.
    a_bool_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_mode != rdz_pkg::MODE_BOOL |-> !bool_out)
        else $error("button value on an axis result");

    a_bool_no_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_mode == rdz_pkg::MODE_BOOL |-> !in_dead_zone)
        else $error("boolean result flagged inside the dead zone");

    // A single-axis result never has second or third components.
    a_axis1_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_mode == rdz_pkg::MODE_AXIS1 |-> out_y == '0 && out_z == '0)
        else $error("single-axis result with extra components");

    // A held result keeps the whole pipeline frozen.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && !in_ready || out_ready)
        else $error("pipeline moved during an output stall");

endmodule
